/* rtl/egcd_pkg.sv */
`timescale 1ns / 1ps
// Package for the extended GCD unit: word types, field widths and defaults.
// Used by extended_gcd_unit; depends on nothing.
package egcd_pkg;

  localparam int OPND_WIDTH = 63;
  localparam int COEF_WIDTH = 64;
  localparam int DATA_WIDTH_DEFAULT = 64;

  // Upper bound on the number of Euclid steps for one word.
  localparam int GUARD_WIDTH = 8;
  localparam logic [GUARD_WIDTH-1:0] GUARD_LIMIT = 8'd200;

  typedef struct packed {
    logic [OPND_WIDTH-1:0] a_value;
    logic [OPND_WIDTH-1:0] b_value;
  } in_word_t;

  typedef struct packed {
    logic [OPND_WIDTH-1:0]        divisor;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
  } out_word_t;

endpackage

/* rtl/egcd_divider.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider that also forms quotient*x and quotient*y.
// Uses no package items; instantiated by extended_gcd_unit.
module egcd_divider #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DATA_WIDTH-2:0]   dividend,
  input  logic [DATA_WIDTH-2:0]   divisor,
  input  logic [DATA_WIDTH-1:0]   x_mult,
  input  logic [DATA_WIDTH-1:0]   y_mult,
  output logic                    done,
  output logic [DATA_WIDTH-2:0]   remainder,
  output logic [DATA_WIDTH-1:0]   qx_prod,
  output logic [DATA_WIDTH-1:0]   qy_prod
);

  localparam int N = DATA_WIDTH - 1;
  localparam int CW = $clog2(N + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(N);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [N-1:0]      num_r, num_nxt;
  logic [N-1:0]      rem_r, rem_nxt;
  logic [N-1:0]      den_r, den_nxt;
  logic [DATA_WIDTH-1:0] xm_r, xm_nxt, ym_r, ym_nxt;
  logic [DATA_WIDTH-1:0] px_r, px_nxt, py_r, py_nxt;

  logic [N:0] trial;
  logic [N:0] diff;
  logic       qbit;

  always_comb begin
    trial = {rem_r, num_r[N-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = ~diff[N];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    xm_nxt   = xm_r;
    ym_nxt   = ym_r;
    px_nxt   = px_r;
    py_nxt   = py_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_FULL;
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      xm_nxt   = x_mult;
      ym_nxt   = y_mult;
      px_nxt   = '0;
      py_nxt   = '0;
    end else if (busy_r) begin
      // Quotient bits come out MSB first, so the products build up Horner style.
      num_nxt = {num_r[N-2:0], 1'b0};
      rem_nxt = qbit ? diff[N-1:0] : trial[N-1:0];
      px_nxt  = {px_r[DATA_WIDTH-2:0], 1'b0} + (qbit ? xm_r : '0);
      py_nxt  = {py_r[DATA_WIDTH-2:0], 1'b0} + (qbit ? ym_r : '0);
      cnt_nxt = cnt_r - CNT_LAST;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    xm_r  <= xm_nxt;
    ym_r  <= ym_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;
  assign qx_prod   = px_r;
  assign qy_prod   = py_r;

endmodule

/* rtl/extended_gcd_unit.sv */
`timescale 1ns / 1ps
// Extended Euclid unit: gcd and Bezout coefficients of two operands.
// Depends on egcd_pkg and egcd_divider.
//
//   Channel | Ports                          | Word
//   input   | in_valid, in_ready, in_data    | egcd_pkg::in_word_t
//   result  | out_valid, out_ready, out_data | egcd_pkg::out_word_t
//
// Each Euclid step runs through check, divider start and a wait on the shared
// bit-serial divider, which also forms q*x and q*y; the update is made on its done.
// Reset is synchronous and clears the sequencer and the output valid.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next word is accepted and worked on.
module extended_gcd_unit #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  egcd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output egcd_pkg::out_word_t out_data
);

  localparam int N = DATA_WIDTH - 1;
  localparam logic [DATA_WIDTH-1:0] COEF_ONE = DATA_WIDTH'(1);
  localparam logic [egcd_pkg::GUARD_WIDTH-1:0] GUARD_ONE = egcd_pkg::GUARD_WIDTH'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [egcd_pkg::GUARD_WIDTH-1:0] guard_r, guard_nxt;
  logic [N-1:0] rold_r, rold_nxt, rcur_r, rcur_nxt;
  logic [DATA_WIDTH-1:0] xold_r, xold_nxt, xcur_r, xcur_nxt;
  logic [DATA_WIDTH-1:0] yold_r, yold_nxt, ycur_r, ycur_nxt;
  logic out_valid_r, out_valid_nxt;
  egcd_pkg::out_word_t out_data_r, out_data_nxt;

  logic div_start;
  logic div_done;
  logic [N-1:0] div_rem;
  logic [DATA_WIDTH-1:0] div_qx, div_qy;

  logic [egcd_pkg::OPND_WIDTH-1:0] div_ext;
  logic [egcd_pkg::COEF_WIDTH-1:0] xa_ext, yb_ext;

  egcd_divider #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rold_r),
    .divisor   (rcur_r),
    .x_mult    (xcur_r),
    .y_mult    (ycur_r),
    .done      (div_done),
    .remainder (div_rem),
    .qx_prod   (div_qx),
    .qy_prod   (div_qy)
  );

  always_comb begin
    div_ext = '0;
    div_ext[N-1:0] = rold_r;
    xa_ext = {egcd_pkg::COEF_WIDTH{xold_r[DATA_WIDTH-1]}};
    xa_ext[DATA_WIDTH-1:0] = xold_r;
    yb_ext = {egcd_pkg::COEF_WIDTH{yold_r[DATA_WIDTH-1]}};
    yb_ext[DATA_WIDTH-1:0] = yold_r;
  end

  always_comb begin
    state_nxt     = state_r;
    guard_nxt     = guard_r;
    rold_nxt      = rold_r;
    rcur_nxt      = rcur_r;
    xold_nxt      = xold_r;
    xcur_nxt      = xcur_r;
    yold_nxt      = yold_r;
    ycur_nxt      = ycur_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rold_nxt  = in_data.a_value[N-1:0];
          rcur_nxt  = in_data.b_value[N-1:0];
          xold_nxt  = COEF_ONE;
          xcur_nxt  = '0;
          yold_nxt  = '0;
          ycur_nxt  = COEF_ONE;
          guard_nxt = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rcur_r == '0 || guard_r == egcd_pkg::GUARD_LIMIT) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          rold_nxt  = rcur_r;
          rcur_nxt  = div_rem;
          xold_nxt  = xcur_r;
          xcur_nxt  = xold_r - div_qx;
          yold_nxt  = ycur_r;
          ycur_nxt  = yold_r - div_qy;
          guard_nxt = guard_r + GUARD_ONE;
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE: begin
        // Hold the result here until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.divisor = div_ext;
          out_data_nxt.coef_a  = xa_ext;
          out_data_nxt.coef_b  = yb_ext;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      guard_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      guard_r     <= guard_nxt;
    end
    rold_r     <= rold_nxt;
    rcur_r     <= rcur_nxt;
    xold_r     <= xold_nxt;
    xcur_r     <= xcur_nxt;
    yold_r     <= yold_nxt;
    ycur_r     <= ycur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
